// File: sv/set_assoc_lru_cache_model_unit_assert.svh
// Assertion macros used by the cache tag store datapath.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_UNIT_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define SALC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define SALC_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);
`else
`define SALC_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define SALC_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif
`endif

// File: sv/salc_pkg.sv
// Types and constants shared by the cache tag store modules.
package salc_pkg;

    localparam int ADDR_W      = 64;
    localparam int CMD_W       = 2;
    localparam int TAG_W       = 62;
    localparam int STAMP_W     = 64;
    localparam int CNT_W       = 32;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 104;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

    // Access commands.
    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } line_t;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic mem_rd;
        logic scan_step;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_drop;
        logic way_match;
        logic way_last;
        logic out_free;
        logic more;
        logic clear_last;
    } dp_status_t;

endpackage

// File: sv/set_assoc_lru_cache_model_unit.sv
// Top level of the set-associative cache tag store with LRU replacement.
//
//  Channel   | Direction | Handshake               | Contents
//  ----------+-----------+-------------------------+----------------------------------------
//  s_axis    | in        | s_axis_tvalid/tready    | one access word: address, command
//  m_axis    | out       | m_axis_tvalid/tready    | one result word per access, tlast on final
//  cfg       | in        | cfg_wr_en (no wait)     | set_bits, ways_in_use, block_bits
//
// After reset the block sweeps the set memory clear, one set per cycle, through all MAX_SETS sets
// with s_axis_tready low; configuration writes are taken during the sweep.
// One access reads the row of its set, then scans the ways in order until the hit way or, on
// a miss, the last way in use, and then updates the row. A modify word runs two accesses
// back to back. The way scan compares one way per cycle against the tag and the oldest
// stamp seen so far. A new access word is taken only after the last update of the previous one.
// Results wait in a one-word output register; the block keeps working on the next word and
// stalls only when a new result is ready while the previous one has not been taken.
module set_assoc_lru_cache_model_unit #(
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_wr_en,
    input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Access words.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: address[63:0], command[65:64], zero pad[71:66].
    input  logic [salc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Result words.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: hit[0], evicted[1], total_hits[33:2], total_misses[65:34],
    // total_evictions[97:66], zero pad[103:98].
    output logic [salc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast
);

    salc_pkg::ctrl_cmd_t  cmd;
    salc_pkg::dp_status_t status;

    // The sequencer sees tvalid of the input and, through in_drop, the unused command code;
    // words with that code are accepted and dropped without touching the state.
    salc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    salc_dpath #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_address (s_axis_tdata[salc_pkg::ADDR_W-1:0]),
        .in_command (s_axis_tdata[salc_pkg::ADDR_W +: salc_pkg::CMD_W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

// File: sv/salc_ctrl.sv
// Sequencer of the cache tag store: clearing sweep, set read, way scan and update.
module salc_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  salc_pkg::dp_status_t   status,
    output salc_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && !status.in_drop)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.way_match || status.way_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = status.more ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        in_ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// File: sv/salc_dpath.sv
// Datapath of the cache tag store: configuration, set memory, way scan, counters, result register.
`include "set_assoc_lru_cache_model_unit_assert.svh"
module salc_dpath #(
    parameter int MAX_SETS   = 256,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [salc_pkg::ADDR_W-1:0]          in_address,
    input  logic [salc_pkg::CMD_W-1:0]           in_command,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [salc_pkg::OUT_TDATA_W-1:0]     out_data,
    output logic                                 out_last,
    input  salc_pkg::ctrl_cmd_t                  cmd,
    output salc_pkg::dp_status_t                 status
);

    localparam int SET_W   = $clog2(MAX_SETS);
    localparam int SET_CAP = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
    localparam logic [salc_pkg::ADDR_W-1:0] ADDR_MASK =
        (ADDR_WIDTH >= salc_pkg::ADDR_W) ? '1 : ((64'd1 << ADDR_WIDTH) - 64'd1);

    typedef salc_pkg::line_t [MAX_WAYS-1:0] row_t;

    // Configuration registers.
    logic [3:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [5:0] block_bits_reg;

    // Address split.
    logic [salc_pkg::ADDR_W-1:0] addr_m;
    logic [3:0]                  sb;
    logic [6:0]                  tag_sh;
    logic [salc_pkg::ADDR_W-1:0] idx_shifted;
    logic [salc_pkg::ADDR_W-1:0] tag_shifted;
    logic [SET_W-1:0]            set_mask;
    logic [SET_W-1:0]            set_now;
    logic [WCNT_W-1:0]           ways_eff;

    // Access registers.
    logic [SET_W-1:0]             set_reg;
    logic [salc_pkg::TAG_W-1:0]   tag_reg;
    logic                         is_mod_reg;
    logic                         second_reg;
    row_t                         row_reg;
    row_t                         wrow;
    logic [WAY_W-1:0]             way_cnt_reg;
    logic [WAY_W-1:0]             sel_way_reg;
    logic [salc_pkg::STAMP_W-1:0] best_reg;
    logic                         hit_reg;
    logic [SET_W-1:0]             clr_cnt_reg;
    salc_pkg::line_t              cur_line;
    salc_pkg::line_t              vict_line;
    logic                         way_match;
    logic                         evict_now;

    // Statistics.
    logic [salc_pkg::STAMP_W-1:0] use_clock_reg;
    logic [salc_pkg::CNT_W-1:0]   hits_reg;
    logic [salc_pkg::CNT_W-1:0]   misses_reg;
    logic [salc_pkg::CNT_W-1:0]   evicts_reg;
    logic [salc_pkg::CNT_W-1:0]   hits_next;
    logic [salc_pkg::CNT_W-1:0]   misses_next;
    logic [salc_pkg::CNT_W-1:0]   evicts_next;

    // Result register.
    logic                         out_valid_reg;
    logic                         out_hit_reg;
    logic                         out_evict_reg;
    logic [salc_pkg::CNT_W-1:0]   out_hits_reg;
    logic [salc_pkg::CNT_W-1:0]   out_misses_reg;
    logic [salc_pkg::CNT_W-1:0]   out_evicts_reg;
    logic                         out_last_reg;

    row_t mem [MAX_SETS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 4'd1;
            ways_reg       <= 4'd1;
            block_bits_reg <= 6'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                salc_pkg::CFG_SET_BITS:   set_bits_reg   <= cfg_wdata[3:0];
                salc_pkg::CFG_WAYS:       ways_reg       <= cfg_wdata[3:0];
                salc_pkg::CFG_BLOCK_BITS: block_bits_reg <= cfg_wdata;
                default:                  ;
            endcase
        end
    end

    // Set index and tag of the incoming address; set bits are capped to the memory depth.
    always_comb
    begin
        addr_m      = in_address & ADDR_MASK;
        sb          = (int'(set_bits_reg) > SET_CAP) ? 4'(SET_CAP) : set_bits_reg;
        tag_sh      = {3'b000, sb} + {1'b0, block_bits_reg};
        idx_shifted = addr_m >> block_bits_reg;
        tag_shifted = (tag_sh >= 7'd64) ? '0 : (addr_m >> tag_sh);
        for (int i = 0; i < SET_W; i++)
        begin
            set_mask[i] = (i < int'(sb));
        end
        set_now = idx_shifted[SET_W-1:0] & set_mask;
    end

    always_comb
    begin
        if (ways_reg == 4'd0)
        begin
            ways_eff = WCNT_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WCNT_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WCNT_W'(ways_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            set_reg    <= set_now;
            tag_reg    <= tag_shifted[salc_pkg::TAG_W-1:0];
            is_mod_reg <= (in_command == salc_pkg::CMD_MODIFY);
        end
    end

    // Set memory: one row holds every way of a set.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.update)
        begin
            mem[set_reg] <= wrow;
        end
        if (cmd.mem_rd)
        begin
            row_reg <= mem[set_reg];
        end
    end

    assign cur_line  = row_reg[way_cnt_reg];
    assign vict_line = row_reg[sel_way_reg];
    assign way_match = cur_line.valid && (cur_line.tag == tag_reg);
    assign evict_now = !hit_reg && vict_line.valid;

    always_comb
    begin
        wrow              = row_reg;
        wrow[sel_way_reg] = '{valid: 1'b1, tag: tag_reg, stamp: use_clock_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            way_cnt_reg <= '0;
            hit_reg     <= 1'b0;
            second_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            if (cmd.capture)
            begin
                second_reg <= 1'b0;
            end
            else if (cmd.update && status.more)
            begin
                second_reg <= 1'b1;
            end
            if (cmd.mem_rd)
            begin
                way_cnt_reg <= '0;
                hit_reg     <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                way_cnt_reg <= way_cnt_reg + WAY_W'(1);
                if (way_match)
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // Lowest matching way wins; otherwise the oldest stamp, lowest way on ties.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            if (way_match)
            begin
                sel_way_reg <= way_cnt_reg;
            end
            else if ((way_cnt_reg == '0) || (cur_line.stamp < best_reg))
            begin
                best_reg    <= cur_line.stamp;
                sel_way_reg <= way_cnt_reg;
            end
        end
    end

    assign hits_next   = (hit_reg && (hits_reg != '1)) ? hits_reg + 1'b1 : hits_reg;
    assign misses_next = (!hit_reg && (misses_reg != '1)) ? misses_reg + 1'b1 : misses_reg;
    assign evicts_next = (evict_now && (evicts_reg != '1)) ? evicts_reg + 1'b1 : evicts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_clock_reg <= 64'd1;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evicts_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                use_clock_reg <= use_clock_reg + 1'b1;
                hits_reg      <= hits_next;
                misses_reg    <= misses_next;
                evicts_reg    <= evicts_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_hit_reg    <= hit_reg;
            out_evict_reg  <= evict_now;
            out_hits_reg   <= hits_next;
            out_misses_reg <= misses_next;
            out_evicts_reg <= evicts_next;
            out_last_reg   <= !status.more;
        end
    end

    assign status.in_drop    = (in_command == salc_pkg::CMD_NONE);
    assign status.way_match  = way_match;
    assign status.way_last   = ((WCNT_W'(way_cnt_reg) + WCNT_W'(1)) == ways_eff);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.more       = is_mod_reg && !second_reg;
    assign status.clear_last = (clr_cnt_reg == SET_W'(MAX_SETS - 1));

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {6'd0, out_evicts_reg, out_misses_reg, out_hits_reg,
                        out_evict_reg, out_hit_reg};

    `SALC_ASSERT(a_no_overwrite, clk, rst_n, cmd.update |-> (!out_valid_reg || out_ready), "result register overwritten before it was taken")
    `SALC_ASSERT(a_miss_count, clk, rst_n, (cmd.update && !hit_reg && (misses_reg != '1)) |=> (misses_reg == $past(misses_reg) + 1'b1), "miss count did not advance on a miss")
    `SALC_ASSERT_NEVER(a_hit_and_evict, clk, rst_n, out_valid_reg && out_hit_reg && out_evict_reg, "a hit reported an eviction")
    `SALC_ASSERT(a_scan_range, clk, rst_n, cmd.scan_step |-> (WCNT_W'(way_cnt_reg) < ways_eff), "way scan ran past the ways in use")

endmodule

// File: bench/tb.sv
// Self-checking bench for the set-associative LRU cache tag store.
`timescale 1ns / 100ps

module tb;

    // Block parameters, passed to the instance so the mirror below agrees with it.
    localparam int MAX_SETS   = 256;
    localparam int MAX_WAYS   = 8;
    localparam int ADDR_WIDTH = 64;
    localparam int NUM_LINES  = MAX_SETS * MAX_WAYS;

    // Widest set index that still fits in MAX_SETS; wider settings are clamped to it.
    localparam int SET_CAP = $clog2(MAX_SETS + 1) - 1;
    localparam logic [salc_pkg::ADDR_W-1:0] ADDR_MASK =
        {salc_pkg::ADDR_W{1'b1}} >> (64 - ADDR_WIDTH);
    localparam logic [63:0] TAG_MASK = {2'b00, {62{1'b1}}};

    // Load and store behave alike; only this bench names them.
    localparam logic [salc_pkg::CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [salc_pkg::CMD_W-1:0] CMD_STORE = 2'd1;

    // A modify runs two accesses of up to MAX_WAYS scan steps each; this is a
    // comfortable margin over that before the block is treated as idle.
    localparam int IDLE_GUARD = 4 * MAX_WAYS + 16;
    // Time limit of the whole run, in ns.
    localparam longint TIME_LIMIT = 20_000_000;

    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 250;

    // Fields of one result word as the block reports them.
    typedef struct packed {
        logic                       hit;
        logic                       evicted;
        logic [salc_pkg::CNT_W-1:0] hits;
        logic [salc_pkg::CNT_W-1:0] misses;
        logic [salc_pkg::CNT_W-1:0] evictions;
        logic                       last;
    } access_result_t;

    // Mirror of the tag store: it replays every accepted access word against its
    // own copy of the lines and counters and queues the result words the block owes.
    class lru_tag_mirror;
        bit                           line_valid [NUM_LINES];
        logic [salc_pkg::TAG_W-1:0]   line_tag   [NUM_LINES];
        logic [salc_pkg::STAMP_W-1:0] line_stamp [NUM_LINES];
        logic [salc_pkg::STAMP_W-1:0] use_clock;
        logic [salc_pkg::CNT_W-1:0]   hit_total;
        logic [salc_pkg::CNT_W-1:0]   miss_total;
        logic [salc_pkg::CNT_W-1:0]   evict_total;
        logic [3:0]                   set_bits;
        logic [3:0]                   ways_in_use;
        logic [5:0]                   block_bits;
        access_result_t               pending[$];
        int                           errors;

        function new();
            for (int i = 0; i < NUM_LINES; i++)
            begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_stamp[i] = '0;
            end
            use_clock   = 64'd1;
            hit_total   = '0;
            miss_total  = '0;
            evict_total = '0;
            set_bits    = 4'd1;
            ways_in_use = 4'd1;
            block_bits  = 6'd1;
            errors      = 0;
        endfunction

        function void set_reg(logic [salc_pkg::CFG_IDX_W-1:0] index,
                              logic [salc_pkg::CFG_DATA_W-1:0] data);
            case (index)
                salc_pkg::CFG_SET_BITS:   set_bits    = data[3:0];
                salc_pkg::CFG_WAYS:       ways_in_use = data[3:0];
                salc_pkg::CFG_BLOCK_BITS: block_bits  = data[5:0];
                default: ;
            endcase
        endfunction

        function access_result_t one_access(logic [salc_pkg::ADDR_W-1:0] addr,
                                            logic final_one);
            access_result_t r;
            int             sb_eff;
            int             ways_eff;
            int             victim;
            int             idx;
            int             base;
            int             w;
            logic [63:0]    a;
            logic [63:0]    set_idx;
            logic [63:0]    tag_val;
            logic [63:0]    oldest;
            bit             seen;

            r = '0;
            a = addr & ADDR_MASK;
            sb_eff = (int'(set_bits) > SET_CAP) ? SET_CAP : int'(set_bits);
            if (ways_in_use == 0)
                ways_eff = 1;
            else if (int'(ways_in_use) > MAX_WAYS)
                ways_eff = MAX_WAYS;
            else
                ways_eff = int'(ways_in_use);

            set_idx = (a >> block_bits) & ((64'd1 << sb_eff) - 64'd1);
            if (set_idx >= MAX_SETS)
                set_idx = '0;
            // Shifts past the address width leave a tag of zero.
            tag_val = (sb_eff + int'(block_bits) >= 64) ? 64'd0 : (a >> (sb_eff + block_bits));
            tag_val = tag_val & TAG_MASK;

            base   = int'(set_idx) * MAX_WAYS;
            victim = 0;
            oldest = '0;
            seen   = 1'b0;
            for (w = 0; w < ways_eff; w++)
            begin
                idx = base + w;
                if (line_valid[idx] && line_tag[idx] == tag_val[salc_pkg::TAG_W-1:0])
                begin
                    line_stamp[idx] = use_clock;
                    use_clock = use_clock + 1;
                    if (hit_total != '1)
                        hit_total = hit_total + 1;
                    r.hit = 1'b1;
                    break;
                end
                // Strict compare keeps the lowest way among equal stamps.
                if (!seen || line_stamp[idx] < oldest)
                begin
                    oldest = line_stamp[idx];
                    victim = w;
                    seen   = 1'b1;
                end
            end

            if (!r.hit)
            begin
                idx = base + victim;
                if (miss_total != '1)
                    miss_total = miss_total + 1;
                if (line_valid[idx])
                begin
                    if (evict_total != '1)
                        evict_total = evict_total + 1;
                    r.evicted = 1'b1;
                end
                line_valid[idx] = 1'b1;
                line_tag[idx]   = tag_val[salc_pkg::TAG_W-1:0];
                line_stamp[idx] = use_clock;
                use_clock = use_clock + 1;
            end

            r.hits      = hit_total;
            r.misses    = miss_total;
            r.evictions = evict_total;
            r.last      = final_one;
            return r;
        endfunction

        // An accepted access word: queue the one or two result words it causes, or none for the unused command.
        function void note_access(logic [salc_pkg::ADDR_W-1:0] addr,
                                  logic [salc_pkg::CMD_W-1:0] cmd);
            if (cmd == salc_pkg::CMD_NONE)
                return;
            if (cmd == salc_pkg::CMD_MODIFY)
                pending.push_back(one_access(addr, 1'b0));
            pending.push_back(one_access(addr, 1'b1));
        endfunction

        // An accepted result word: compare it with the oldest one still owed.
        function void check_result(logic [salc_pkg::OUT_TDATA_W-1:0] data, logic last_flag);
            access_result_t want;
            access_result_t got;

            got.hit       = data[0];
            got.evicted   = data[1];
            got.hits      = data[33:2];
            got.misses    = data[65:34];
            got.evictions = data[97:66];
            got.last      = last_flag;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("tb: unexpected result word %h last %b", data, last_flag);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $write("tb: mismatch (expected/actual) hit %b/%b evicted %b/%b",
                           want.hit, got.hit, want.evicted, got.evicted);
                    $display(" hits %0d/%0d misses %0d/%0d evictions %0d/%0d last %b/%b",
                             want.hits, got.hits, want.misses, got.misses,
                             want.evictions, got.evictions, want.last, got.last);
                end
            end
        endfunction
    endclass

    // Every input of the block is known from time zero.
    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             cfg_wr_en     = 1'b0;
    logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [salc_pkg::CFG_DATA_W-1:0]  cfg_wdata     = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [salc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [salc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;

    lru_tag_mirror mirror;
    // Remaining words of a no-idle stretch, one counter per side.
    int sender_calm   = 0;
    int receiver_calm = 0;

    set_assoc_lru_cache_model_unit #(
        .MAX_SETS   (MAX_SETS),
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // Idle gap before the next word on one side, drawn at random, with the odd
    // stretch of back-to-back words so that full-rate operation is also seen.
    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // Most addresses come from a few sets and a dozen tags under the current
    // layout, so sets fill up and lines get hit and evicted; the rest are noise.
    function automatic logic [salc_pkg::ADDR_W-1:0] pick_address();
        int          sb_eff;
        int          bb;
        logic [63:0] offset;

        sb_eff = (int'(mirror.set_bits) > SET_CAP) ? SET_CAP : int'(mirror.set_bits);
        bb     = int'(mirror.block_bits);
        offset = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 2)
            return offset;
        return (64'($urandom_range(0, 11)) << (sb_eff + bb))
             | (64'($urandom_range(0, 3)) << bb)
             | (offset & ((64'd1 << bb) - 64'd1));
    endfunction

    function automatic logic [salc_pkg::CMD_W-1:0] pick_command();
        int r;

        r = $urandom_range(0, 99);
        if (r < 4)
            return salc_pkg::CMD_NONE;
        else if (r < 36)
            return CMD_LOAD;
        else if (r < 68)
            return CMD_STORE;
        return salc_pkg::CMD_MODIFY;
    endfunction

    // Offer one access word and hold it until the block takes it. Called at a
    // rising edge; returns at the edge where the word was accepted.
    task automatic send_access(logic [salc_pkg::ADDR_W-1:0] addr,
                               logic [salc_pkg::CMD_W-1:0] cmd);
        int gap;

        gap = draw_gap(sender_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(salc_pkg::IN_TDATA_W - salc_pkg::ADDR_W - salc_pkg::CMD_W){1'b0}},
                          cmd, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        mirror.note_access(addr, cmd);
    endtask

    // Wait until every owed result has come back, then give the block time to
    // finish an ignored word that may still be in flight.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (mirror.pending.size() != 0)
            @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    // Writes all three registers on consecutive edges; the enable is lowered
    // only once, after the last one.
    task automatic write_config(logic [salc_pkg::CFG_DATA_W-1:0] sb_raw,
                                logic [salc_pkg::CFG_DATA_W-1:0] ways_raw,
                                logic [salc_pkg::CFG_DATA_W-1:0] bb_raw);
        cfg_wr_en <= 1'b1;
        cfg_index <= salc_pkg::CFG_SET_BITS;
        cfg_wdata <= sb_raw;
        @(posedge clk);
        mirror.set_reg(salc_pkg::CFG_SET_BITS, sb_raw);
        cfg_index <= salc_pkg::CFG_WAYS;
        cfg_wdata <= ways_raw;
        @(posedge clk);
        mirror.set_reg(salc_pkg::CFG_WAYS, ways_raw);
        cfg_index <= salc_pkg::CFG_BLOCK_BITS;
        cfg_wdata <= bb_raw;
        @(posedge clk);
        mirror.set_reg(salc_pkg::CFG_BLOCK_BITS, bb_raw);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: stall at random, then take one word and check it.
    initial
    begin
        int stall;

        @(posedge clk);
        forever
        begin
            stall = draw_gap(receiver_calm);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            mirror.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    initial
    begin
        logic [salc_pkg::CFG_DATA_W-1:0] sb_raw;
        logic [salc_pkg::CFG_DATA_W-1:0] ways_raw;
        logic [salc_pkg::CFG_DATA_W-1:0] bb_raw;

        mirror = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset layout: one way, two sets, two-byte blocks.
        // The block is still sweeping its lines here; the first word waits for it.
        send_access(64'd0, CMD_LOAD);                   // cold miss
        send_access(64'd0, CMD_STORE);                  // hit
        send_access(64'd1, CMD_LOAD);                   // same block, hit
        send_access(64'd2, CMD_LOAD);                   // other set, cold miss
        send_access(64'd4, CMD_LOAD);                   // new tag in set 0, eviction
        send_access(64'd0, salc_pkg::CMD_NONE);         // unknown command, no result
        send_access(64'd0, salc_pkg::CMD_MODIFY);       // eviction, then hit
        send_access({64{1'b1}}, CMD_LOAD);
        send_access({64{1'b1}}, salc_pkg::CMD_MODIFY);
        send_access(64'h8000_0000_0000_0000, CMD_STORE);
        send_access({64{1'b1}}, salc_pkg::CMD_NONE);
        settle();

        // No set or block bits and a way count of zero: the whole address is the
        // tag, so its two top bits are lost and these addresses alias.
        write_config(6'd0, 6'd0, 6'd0);
        send_access(64'h0000_0000_0000_0005, CMD_LOAD);
        send_access(64'hC000_0000_0000_0005, CMD_LOAD);
        send_access(64'h4000_0000_0000_0005, salc_pkg::CMD_MODIFY);
        send_access(64'h0000_0000_0000_0006, CMD_STORE);
        settle();

        // All fields at their maximum: the set width is clamped, the tag shift
        // runs past the address and the way count is clamped.
        write_config(6'h3F, 6'h3F, 6'h3F);
        send_access({64{1'b1}}, CMD_LOAD);
        send_access(64'h8000_0000_0000_0000, CMD_LOAD);
        send_access(64'd0, CMD_LOAD);
        send_access(64'd12345, salc_pkg::CMD_MODIFY);
        settle();

        // The set index sits in the top byte and the tag shift is exactly 64.
        write_config(6'd8, 6'd8, 6'd56);
        send_access(64'hFF00_0000_0000_0000, CMD_LOAD);
        send_access(64'hFF12_3456_789A_BCDE, CMD_STORE);
        send_access(64'h0100_0000_0000_0000, salc_pkg::CMD_MODIFY);
        settle();

        // Random phases: first the low and high ends of the stated ranges and one middle
        // layout, then random layouts, mostly small so that sets see conflicts.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: begin sb_raw = 6'd1; ways_raw = 6'd1; bb_raw = 6'd1;  end
                1: begin sb_raw = 6'd8; ways_raw = 6'd8; bb_raw = 6'd32; end
                2: begin sb_raw = 6'd2; ways_raw = 6'd4; bb_raw = 6'd3;  end
                default:
                begin
                    // The upper two data bits of the four-bit registers are junk.
                    sb_raw   = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                           : 6'($urandom_range(1, 4));
                    ways_raw = 6'($urandom_range(0, 63));
                    bb_raw   = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                           : 6'($urandom_range(0, 8));
                end
            endcase
            write_config(sb_raw, ways_raw, bb_raw);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_access(pick_address(), pick_command());
            settle();
        end

        // settle() has drained the result queue and waited out the pipeline.
        if (mirror.errors == 0 && mirror.pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #(TIME_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

endmodule
